// File: src/ppc_pkg.sv
// ---------------------------------------------------------------------------
// ppc_pkg: shared definitions for the prefetch phase controller
// Phase, operation and abort codes, table geometry and the command and
// status bundles between the controller and the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package ppc_pkg;

  // Cooldown table geometry.
  localparam int SKIP_ENTRIES = 8;
  localparam int IDX_W = (SKIP_ENTRIES > 1) ? $clog2(SKIP_ENTRIES) : 1;

  localparam logic [31:0] COOLDOWN_RESET = 32'd300000;
  localparam logic [31:0] SIGN_FLIP = 32'h8000_0000;

  // Phases.
  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_SELECTING = 3'd1;
  localparam logic [2:0] PH_PENDING   = 3'd2;
  localparam logic [2:0] PH_FETCHING  = 3'd3;
  localparam logic [2:0] PH_DONE      = 3'd4;
  localparam logic [2:0] PH_FAILED    = 3'd5;
  localparam logic [2:0] PH_DRAINED   = 3'd6;

  // Operations.
  localparam logic [2:0] OP_SERVICE   = 3'd0;
  localparam logic [2:0] OP_NIGHT     = 3'd1;
  localparam logic [2:0] OP_CANDIDATE = 3'd2;
  localparam logic [2:0] OP_DRAINED   = 3'd3;
  localparam logic [2:0] OP_PREEMPT   = 3'd4;
  localparam logic [2:0] OP_YIELD     = 3'd5;
  localparam logic [2:0] OP_QUERY     = 3'd6;
  localparam logic [2:0] OP_FAILURE   = 3'd7;

  // Abort reasons.
  localparam logic [1:0] ABORT_NONE    = 2'd0;
  localparam logic [1:0] ABORT_PREEMPT = 2'd1;
  localparam logic [1:0] ABORT_USER    = 2'd2;
  localparam logic [1:0] ABORT_STREAM  = 2'd3;

  typedef struct packed {
    logic latch;    // capture the input item
    logic scan_rd;  // read the next cooldown table entry
    logic exec;     // commit the step and load the result register
  } cmd_t;

  typedef struct packed {
    logic need_scan;  // item at the input port consults the table
    logic scan_last;  // the last table entry is being read
  } sts_t;

endpackage

`default_nettype wire

// File: src/ppc_ctrl.sv
// ---------------------------------------------------------------------------
// ppc_ctrl: sequencer for the prefetch phase controller
// Takes one item at a time, runs the cooldown table scan when the item
// needs it, commits the step and owns the result valid flag.
// ---------------------------------------------------------------------------
`default_nettype none

module ppc_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire               out_ready,
  input  ppc_pkg::sts_t     sts,
  output ppc_pkg::cmd_t     cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_EXEC  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next  = state;
    cmd.latch   = 1'b0;
    cmd.scan_rd = 1'b0;
    cmd.exec    = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = sts.need_scan ? S_SCAN : S_EXEC;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // The last entry read is evaluated during this cycle.
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.exec) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/ppc_dp.sv
// ---------------------------------------------------------------------------
// ppc_dp: datapath of the prefetch phase controller
// Holds the phase and night registers, counters, the cooldown table with
// its scan logic, the configuration register and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module ppc_dp (
  input  wire                 clk,
  input  wire                 rst,
  input  ppc_pkg::cmd_t       cmd,
  output ppc_pkg::sts_t       sts,
  input  wire                 cfg_write,
  input  wire [31:0]          cfg_data,
  input  wire [2:0]           operation,
  input  wire [63:0]          night_id,
  input  wire [31:0]          now_ms,
  input  wire                 stream_active,
  input  wire                 manager_busy,
  input  wire                 catalog_pending,
  input  wire                 fetch_active,
  input  wire                 coverage_complete,
  input  wire                 fetch_start_ok,
  output logic                accepted,
  output logic [2:0]          phase_now,
  output logic [63:0]         active_night_out,
  output logic [63:0]         last_night_out,
  output logic [63:0]         last_failed_out,
  output logic [31:0]         completed_out,
  output logic [31:0]         failed_out,
  output logic                cooldown_hit,
  output logic                fetch_request,
  output logic                abort_fetch,
  output logic [1:0]          abort_reason
);

  // Configuration and architectural state.
  logic [31:0] cooldown_ms;
  logic [2:0]  phase_reg;
  logic [63:0] active_night;
  logic [63:0] last_night;
  logic [63:0] last_failed_night;
  logic [31:0] completed_count;
  logic [31:0] failed_count;
  logic        preempt_pending;

  // Captured item.
  logic [2:0]  op_q;
  logic [63:0] night_q;
  logic [31:0] now_q;
  logic        realtime_q;
  logic        busy_q;
  logic        catalog_q;
  logic        fetching_q;
  logic        covered_q;
  logic        start_ok_q;

  // Cooldown table. An entry that was never written reads as zero.
  logic [63:0] skip_night [ppc_pkg::SKIP_ENTRIES];
  logic [31:0] skip_until [ppc_pkg::SKIP_ENTRIES];
  logic [ppc_pkg::SKIP_ENTRIES-1:0] tab_valid;

  // Scan pipeline.
  logic [ppc_pkg::IDX_W-1:0] scan_idx;
  logic [ppc_pkg::IDX_W-1:0] rd_idx;
  logic        rd_live;
  logic        rd_ok;
  logic [63:0] rd_night_raw;
  logic [31:0] rd_until_raw;
  logic [63:0] rd_night;
  logic [31:0] rd_until;
  logic        found;
  logic        hit;
  logic [ppc_pkg::IDX_W-1:0] pick;
  logic [31:0] pick_until;

  logic [63:0] key;
  logic        key_match;
  logic        entry_hit;
  logic        earlier;
  logic [31:0] rel_new;
  logic [31:0] rel_pick;
  logic [31:0] until_sum;
  logic [31:0] until_val;

  // Next-state values of one step.
  logic [2:0]  phase_next;
  logic [63:0] active_night_next;
  logic [63:0] last_night_next;
  logic [63:0] last_failed_night_next;
  logic [31:0] completed_count_next;
  logic [31:0] failed_count_next;
  logic        preempt_pending_next;
  logic        acc_next;
  logic        cool_next;
  logic        freq_next;
  logic        abort_next;
  logic [1:0]  reason_next;
  logic        table_write;
  logic        busy_phase;

  function automatic logic rel_hit_sign(input logic [31:0] now, input logic [31:0] dl);
    logic [31:0] diff;
    diff = now - dl;
    return diff[31];
  endfunction

  assign sts.need_scan = (operation == ppc_pkg::OP_SERVICE) ||
                         (operation == ppc_pkg::OP_QUERY) ||
                         (operation == ppc_pkg::OP_FAILURE);
  assign sts.scan_last = (scan_idx == ppc_pkg::IDX_W'(ppc_pkg::SKIP_ENTRIES - 1));

  // A service step may log a failure of the active night; the other table
  // users work on the night carried by the item.
  assign key = (op_q == ppc_pkg::OP_SERVICE) ? active_night : night_q;

  assign rd_night  = rd_ok ? rd_night_raw : 64'd0;
  assign rd_until  = rd_ok ? rd_until_raw : 32'd0;
  assign key_match = (rd_night == key);
  assign entry_hit = key_match && (rd_until != 32'd0) && rel_hit_sign(now_q, rd_until);

  // Deadlines are compared relative to the time of the item, as signed values.
  assign rel_new  = (rd_until - now_q) ^ ppc_pkg::SIGN_FLIP;
  assign rel_pick = (pick_until - now_q) ^ ppc_pkg::SIGN_FLIP;
  assign earlier  = (rel_new < rel_pick);

  assign until_sum = now_q + cooldown_ms;
  assign until_val = (until_sum == 32'd0) ? 32'd1 : until_sum;

  always_comb begin
    busy_phase = (phase_reg inside {ppc_pkg::PH_SELECTING, ppc_pkg::PH_PENDING,
                                    ppc_pkg::PH_FETCHING});
    phase_next             = phase_reg;
    active_night_next      = active_night;
    last_night_next        = last_night;
    last_failed_night_next = last_failed_night;
    completed_count_next   = completed_count;
    failed_count_next      = failed_count;
    preempt_pending_next   = preempt_pending;
    acc_next               = 1'b0;
    cool_next              = 1'b0;
    freq_next              = 1'b0;
    abort_next             = 1'b0;
    reason_next            = ppc_pkg::ABORT_NONE;
    table_write            = 1'b0;
    case (op_q)
      ppc_pkg::OP_SERVICE: begin
        preempt_pending_next = 1'b0;
        if (preempt_pending && busy_phase) begin
          if (fetching_q) begin
            abort_next  = 1'b1;
            reason_next = ppc_pkg::ABORT_PREEMPT;
          end
          phase_next        = ppc_pkg::PH_IDLE;
          active_night_next = 64'd0;
        end else if (phase_reg == ppc_pkg::PH_SELECTING) begin
          if (!realtime_q && !busy_q && !catalog_q) begin
            if (night_q != 64'd0) begin
              phase_next        = ppc_pkg::PH_PENDING;
              active_night_next = night_q;
              last_night_next   = night_q;
            end else begin
              phase_next        = ppc_pkg::PH_DRAINED;
              active_night_next = 64'd0;
            end
          end
        end else if (phase_reg == ppc_pkg::PH_FETCHING && !fetching_q) begin
          if (active_night != 64'd0) begin
            last_night_next = active_night;
          end
          if (covered_q) begin
            phase_next           = ppc_pkg::PH_DONE;
            completed_count_next = completed_count + 32'd1;
          end else begin
            phase_next             = ppc_pkg::PH_FAILED;
            failed_count_next      = failed_count + 32'd1;
            last_failed_night_next = active_night;
            table_write            = 1'b1;
          end
        end else if (realtime_q) begin
          if (phase_reg == ppc_pkg::PH_FETCHING && fetching_q) begin
            abort_next        = 1'b1;
            reason_next       = ppc_pkg::ABORT_STREAM;
            phase_next        = ppc_pkg::PH_IDLE;
            active_night_next = 64'd0;
          end
        end else if (phase_reg == ppc_pkg::PH_PENDING && !busy_q) begin
          if (active_night != 64'd0) begin
            freq_next       = 1'b1;
            last_night_next = active_night;
            if (start_ok_q) begin
              phase_next = ppc_pkg::PH_FETCHING;
            end else begin
              // A refused start counts as a failure but sets no cooldown.
              phase_next             = ppc_pkg::PH_FAILED;
              failed_count_next      = failed_count + 32'd1;
              last_failed_night_next = active_night;
            end
          end else begin
            phase_next = ppc_pkg::PH_DRAINED;
          end
        end
      end
      ppc_pkg::OP_NIGHT: begin
        if (night_q != 64'd0 && !busy_phase) begin
          phase_next        = ppc_pkg::PH_PENDING;
          active_night_next = night_q;
          last_night_next   = night_q;
          acc_next          = 1'b1;
        end
      end
      ppc_pkg::OP_CANDIDATE: begin
        if (!busy_phase) begin
          phase_next        = ppc_pkg::PH_SELECTING;
          active_night_next = 64'd0;
          acc_next          = 1'b1;
        end
      end
      ppc_pkg::OP_DRAINED: begin
        if (!busy_phase) begin
          phase_next        = ppc_pkg::PH_DRAINED;
          active_night_next = 64'd0;
        end
      end
      ppc_pkg::OP_PREEMPT: begin
        preempt_pending_next = 1'b1;
      end
      ppc_pkg::OP_YIELD: begin
        if (phase_reg == ppc_pkg::PH_FETCHING) begin
          if (fetching_q) begin
            abort_next  = 1'b1;
            reason_next = ppc_pkg::ABORT_USER;
          end
          phase_next        = ppc_pkg::PH_IDLE;
          active_night_next = 64'd0;
        end
      end
      ppc_pkg::OP_QUERY: begin
        cool_next = hit;
      end
      ppc_pkg::OP_FAILURE: begin
        table_write = 1'b1;
      end
      default: begin
        table_write = 1'b0;
      end
    endcase
  end

  // Configuration, architectural state and the table valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      cooldown_ms       <= ppc_pkg::COOLDOWN_RESET;
      phase_reg         <= ppc_pkg::PH_IDLE;
      active_night      <= 64'd0;
      last_night        <= 64'd0;
      last_failed_night <= 64'd0;
      completed_count   <= 32'd0;
      failed_count      <= 32'd0;
      preempt_pending   <= 1'b0;
      tab_valid         <= '0;
    end else begin
      if (cfg_write) begin
        cooldown_ms <= cfg_data;
      end
      if (cmd.exec) begin
        phase_reg         <= phase_next;
        active_night      <= active_night_next;
        last_night        <= last_night_next;
        last_failed_night <= last_failed_night_next;
        completed_count   <= completed_count_next;
        failed_count      <= failed_count_next;
        preempt_pending   <= preempt_pending_next;
        if (table_write) begin
          tab_valid[pick] <= 1'b1;
        end
      end
    end
  end

  // Table storage: one write port at the chosen slot, one registered read.
  always_ff @(posedge clk) begin
    if (cmd.exec && table_write) begin
      skip_night[pick] <= key;
      skip_until[pick] <= until_val;
    end
    rd_night_raw <= skip_night[scan_idx];
    rd_until_raw <= skip_until[scan_idx];
    rd_ok        <= tab_valid[scan_idx];
    rd_idx       <= scan_idx;
  end

  // Scan control and per-entry evaluation.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_live  <= 1'b0;
      scan_idx <= '0;
      found    <= 1'b0;
      hit      <= 1'b0;
    end else begin
      rd_live <= cmd.scan_rd;
      if (cmd.latch) begin
        scan_idx <= '0;
        found    <= 1'b0;
        hit      <= 1'b0;
      end else if (cmd.scan_rd) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (rd_live) begin
        if (entry_hit) begin
          hit <= 1'b1;
        end
        if (!found && (key_match || rd_night == 64'd0)) begin
          found <= 1'b1;
        end
      end
    end
  end

  // Replacement choice: a matching or empty slot wins outright, otherwise the
  // earliest deadline, with the lowest index kept on ties.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      pick <= '0;
    end else if (rd_live && !found) begin
      if (key_match || rd_night == 64'd0) begin
        pick <= rd_idx;
      end else if (rd_idx == '0 || earlier) begin
        pick       <= rd_idx;
        pick_until <= rd_until;
      end
    end
  end

  // Captured item.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q       <= operation;
      night_q    <= night_id;
      now_q      <= now_ms;
      realtime_q <= stream_active;
      busy_q     <= manager_busy;
      catalog_q  <= catalog_pending;
      fetching_q <= fetch_active;
      covered_q  <= coverage_complete;
      start_ok_q <= fetch_start_ok;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      accepted         <= acc_next;
      phase_now        <= phase_next;
      active_night_out <= active_night_next;
      last_night_out   <= last_night_next;
      last_failed_out  <= last_failed_night_next;
      completed_out    <= completed_count_next;
      failed_out       <= failed_count_next;
      cooldown_hit     <= cool_next;
      fetch_request    <= freq_next;
      abort_fetch      <= abort_next;
      abort_reason     <= reason_next;
    end
  end

endmodule

`default_nettype wire

// File: src/prefetch_phase_controller_with_cooldown.sv
// ---------------------------------------------------------------------------
// prefetch_phase_controller_with_cooldown: background prefetch controller
// Seven-phase prefetch sequencer with failure counters and a cooldown table
// of failed nights, one result per input transfer.
// ---------------------------------------------------------------------------
// Service, query and note-failure items read the cooldown table one entry
// per cycle over 8 entries, then pass a drain state that evaluates the last
// entry and a commit state; all other items go straight to commit. One item
// is taken at a time, and the next is accepted only after the last commits.
// A waiting result does not block the next input.
// Reset (synchronous, active high) returns to idle with an empty table and
// cooldown_ms at 300000.
`default_nettype none

module prefetch_phase_controller_with_cooldown (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_write,
  input  wire  [31:0] cfg_data,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [2:0]  operation,
  input  wire  [63:0] night_id,
  input  wire  [31:0] now_ms,
  input  wire         stream_active,
  input  wire         manager_busy,
  input  wire         catalog_pending,
  input  wire         fetch_active,
  input  wire         coverage_complete,
  input  wire         fetch_start_ok,
  output logic        out_valid,
  input  wire         out_ready,
  output logic        accepted,
  output logic [2:0]  phase_now,
  output logic [63:0] active_night_out,
  output logic [63:0] last_night_out,
  output logic [63:0] last_failed_out,
  output logic [31:0] completed_out,
  output logic [31:0] failed_out,
  output logic        cooldown_hit,
  output logic        fetch_request,
  output logic        abort_fetch,
  output logic [1:0]  abort_reason
);

  ppc_pkg::cmd_t cmd;
  ppc_pkg::sts_t sts;

  ppc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ppc_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_write         (cfg_write),
    .cfg_data          (cfg_data),
    .operation         (operation),
    .night_id          (night_id),
    .now_ms            (now_ms),
    .stream_active     (stream_active),
    .manager_busy      (manager_busy),
    .catalog_pending   (catalog_pending),
    .fetch_active      (fetch_active),
    .coverage_complete (coverage_complete),
    .fetch_start_ok    (fetch_start_ok),
    .accepted          (accepted),
    .phase_now         (phase_now),
    .active_night_out  (active_night_out),
    .last_night_out    (last_night_out),
    .last_failed_out   (last_failed_out),
    .completed_out     (completed_out),
    .failed_out        (failed_out),
    .cooldown_hit      (cooldown_hit),
    .fetch_request     (fetch_request),
    .abort_fetch       (abort_fetch),
    .abort_reason      (abort_reason)
  );

  // Only one item is in flight: a transfer closes the input until committed.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !abort_fetch |-> abort_reason == ppc_pkg::ABORT_NONE)
    else $error("abort reason without abort");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |->
      phase_now == ppc_pkg::PH_PENDING || phase_now == ppc_pkg::PH_SELECTING)
    else $error("accepted request left a wrong phase");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && fetch_request |->
      phase_now == ppc_pkg::PH_FETCHING || phase_now == ppc_pkg::PH_FAILED)
    else $error("fetch request with wrong resulting phase");

endmodule

`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: testbench for prefetch_phase_controller_with_cooldown
// Drives phase requests, service ticks, preempts, yields, cooldown queries and
// failure notes through the input channel. A behavioral copy of the phase
// controller and its cooldown table predicts every status transfer, and each
// status transfer is compared field by field against the oldest prediction.
// ---------------------------------------------------------------------------

module tb;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 16;

  // Condition flag bits for building directed requests.
  localparam logic [5:0] F_NONE = 6'b000000;
  localparam logic [5:0] F_RT   = 6'b100000;
  localparam logic [5:0] F_BUSY = 6'b010000;
  localparam logic [5:0] F_CAT  = 6'b001000;
  localparam logic [5:0] F_FA   = 6'b000100;
  localparam logic [5:0] F_COV  = 6'b000010;
  localparam logic [5:0] F_OK   = 6'b000001;
  localparam logic [5:0] F_ALL  = 6'b111111;

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] night;
    logic [31:0] now;
    logic        rt;
    logic        busy;
    logic        cat;
    logic        fa;
    logic        cov;
    logic        ok;
  } prefetch_req_t;

  typedef struct packed {
    logic        acc;
    logic [2:0]  phase;
    logic [63:0] act;
    logic [63:0] last;
    logic [63:0] lastf;
    logic [31:0] done_cnt;
    logic [31:0] fail_cnt;
    logic        cool;
    logic        freq;
    logic        abort;
    logic [1:0]  reason;
  } prefetch_stat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  op_d = ppc_pkg::OP_QUERY;
  logic [63:0] night_d = '0;
  logic [31:0] now_d = '0;
  logic        rt_d = 1'b0;
  logic        busy_d = 1'b0;
  logic        cat_d = 1'b0;
  logic        fa_d = 1'b0;
  logic        cov_d = 1'b0;
  logic        ok_d = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        accepted;
  logic [2:0]  phase_now;
  logic [63:0] active_night_out;
  logic [63:0] last_night_out;
  logic [63:0] last_failed_out;
  logic [31:0] completed_out;
  logic [31:0] failed_out;
  logic        cooldown_hit;
  logic        fetch_request;
  logic        abort_fetch;
  logic [1:0]  abort_reason;

  prefetch_phase_controller_with_cooldown dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .operation         (op_d),
    .night_id          (night_d),
    .now_ms            (now_d),
    .stream_active     (rt_d),
    .manager_busy      (busy_d),
    .catalog_pending   (cat_d),
    .fetch_active      (fa_d),
    .coverage_complete (cov_d),
    .fetch_start_ok    (ok_d),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .accepted          (accepted),
    .phase_now         (phase_now),
    .active_night_out  (active_night_out),
    .last_night_out    (last_night_out),
    .last_failed_out   (last_failed_out),
    .completed_out     (completed_out),
    .failed_out        (failed_out),
    .cooldown_hit      (cooldown_hit),
    .fetch_request     (fetch_request),
    .abort_fetch       (abort_fetch),
    .abort_reason      (abort_reason)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Controller state as the testbench believes it to be.
  logic [2:0]  ctl_phase = ppc_pkg::PH_IDLE;
  logic [63:0] ctl_active = '0;
  logic [63:0] ctl_last = '0;
  logic [63:0] ctl_lastf = '0;
  logic [31:0] ctl_done = '0;
  logic [31:0] ctl_fail = '0;
  logic        ctl_preempt = 1'b0;
  logic [31:0] ctl_cooldown = ppc_pkg::COOLDOWN_RESET;
  logic [63:0] skip_night [ppc_pkg::SKIP_ENTRIES];
  logic [31:0] skip_until [ppc_pkg::SKIP_ENTRIES];

  prefetch_stat_t status_due [$];
  int mismatch_count = 0;
  int quiet_cycles = 0;
  int burst_left = 0;
  logic [31:0] sim_now = 32'd1000;

  initial begin
    for (int i = 0; i < ppc_pkg::SKIP_ENTRIES; i++) begin
      skip_night[i] = '0;
      skip_until[i] = '0;
    end
  end

  function automatic logic in_flight();
    return ctl_phase == ppc_pkg::PH_SELECTING || ctl_phase == ppc_pkg::PH_PENDING ||
           ctl_phase == ppc_pkg::PH_FETCHING;
  endfunction

  function automatic logic night_cooling(input logic [63:0] night, input logic [31:0] now);
    logic [31:0] diff;
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < ppc_pkg::SKIP_ENTRIES; i++) begin
      diff = now - skip_until[i];
      if (skip_night[i] == night && skip_until[i] != 0 && diff[31]) hit = 1'b1;
    end
    return hit;
  endfunction

  // Take a matching or empty slot; if there is none, replace the slot whose
  // deadline comes first relative to now, lowest index on ties.
  task automatic log_failed_night(input logic [63:0] night, input logic [31:0] now);
    logic [31:0] deadline;
    logic [31:0] da;
    logic [31:0] db;
    int pick;
    logic found;
    deadline = now + ctl_cooldown;
    if (deadline == 0) deadline = 32'd1;
    pick = 0;
    found = 1'b0;
    for (int i = 0; i < ppc_pkg::SKIP_ENTRIES; i++) begin
      if (!found) begin
        if (skip_night[i] == night || skip_night[i] == 0) begin
          pick = i;
          found = 1'b1;
        end else begin
          da = (skip_until[i] - now) ^ ppc_pkg::SIGN_FLIP;
          db = (skip_until[pick] - now) ^ ppc_pkg::SIGN_FLIP;
          if (da < db) pick = i;
        end
      end
    end
    skip_night[pick] = night;
    skip_until[pick] = deadline;
  endtask

  task automatic move_to(input logic [2:0] ph, input logic [63:0] night,
                         input logic inc_done, input logic inc_fail);
    logic [63:0] fail_night;
    fail_night = (night != 0) ? night : ctl_active;
    ctl_phase = ph;
    ctl_active = night;
    if (night != 0) ctl_last = night;
    if (inc_done) ctl_done++;
    if (inc_fail) begin
      ctl_fail++;
      ctl_lastf = fail_night;
      if (fail_night != 0) ctl_last = fail_night;
    end
  endtask

  task automatic step_controller(input prefetch_req_t rq, output prefetch_stat_t st);
    logic pre;
    logic [63:0] act;
    st.acc = 1'b0;
    st.cool = 1'b0;
    st.freq = 1'b0;
    st.abort = 1'b0;
    st.reason = ppc_pkg::ABORT_NONE;
    case (rq.op)
      ppc_pkg::OP_SERVICE: begin
        pre = ctl_preempt;
        act = ctl_active;
        ctl_preempt = 1'b0;
        if (pre && in_flight()) begin
          if (rq.fa) begin
            st.abort = 1'b1;
            st.reason = ppc_pkg::ABORT_PREEMPT;
          end
          move_to(ppc_pkg::PH_IDLE, '0, 1'b0, 1'b0);
        end else if (ctl_phase == ppc_pkg::PH_SELECTING) begin
          if (!rq.rt && !rq.busy && !rq.cat) begin
            if (rq.night != 0) move_to(ppc_pkg::PH_PENDING, rq.night, 1'b0, 1'b0);
            else move_to(ppc_pkg::PH_DRAINED, '0, 1'b0, 1'b0);
          end
        end else if (ctl_phase == ppc_pkg::PH_FETCHING && !rq.fa) begin
          if (!rq.cov) log_failed_night(act, rq.now);
          move_to(rq.cov ? ppc_pkg::PH_DONE : ppc_pkg::PH_FAILED, act, rq.cov, !rq.cov);
        end else if (rq.rt) begin
          if (ctl_phase == ppc_pkg::PH_FETCHING && rq.fa) begin
            st.abort = 1'b1;
            st.reason = ppc_pkg::ABORT_STREAM;
            move_to(ppc_pkg::PH_IDLE, '0, 1'b0, 1'b0);
          end
        end else if (ctl_phase == ppc_pkg::PH_PENDING && !rq.busy) begin
          if (act != 0) begin
            st.freq = 1'b1;
            if (rq.ok) move_to(ppc_pkg::PH_FETCHING, act, 1'b0, 1'b0);
            else move_to(ppc_pkg::PH_FAILED, act, 1'b0, 1'b1);
          end else begin
            move_to(ppc_pkg::PH_DRAINED, '0, 1'b0, 1'b0);
          end
        end
      end
      ppc_pkg::OP_NIGHT: begin
        if (rq.night != 0 && !in_flight()) begin
          ctl_phase = ppc_pkg::PH_PENDING;
          ctl_active = rq.night;
          ctl_last = rq.night;
          st.acc = 1'b1;
        end
      end
      ppc_pkg::OP_CANDIDATE: begin
        if (!in_flight()) begin
          ctl_phase = ppc_pkg::PH_SELECTING;
          ctl_active = '0;
          st.acc = 1'b1;
        end
      end
      ppc_pkg::OP_DRAINED: begin
        if (!in_flight()) begin
          ctl_phase = ppc_pkg::PH_DRAINED;
          ctl_active = '0;
        end
      end
      ppc_pkg::OP_PREEMPT: ctl_preempt = 1'b1;
      ppc_pkg::OP_YIELD: begin
        if (ctl_phase == ppc_pkg::PH_FETCHING) begin
          if (rq.fa) begin
            st.abort = 1'b1;
            st.reason = ppc_pkg::ABORT_USER;
          end
          move_to(ppc_pkg::PH_IDLE, '0, 1'b0, 1'b0);
        end
      end
      ppc_pkg::OP_QUERY: st.cool = night_cooling(rq.night, rq.now);
      default: log_failed_night(rq.night, rq.now);
    endcase
    st.phase = ctl_phase;
    st.act = ctl_active;
    st.last = ctl_last;
    st.lastf = ctl_lastf;
    st.done_cnt = ctl_done;
    st.fail_cnt = ctl_fail;
  endtask

  function automatic prefetch_req_t mk_req(input logic [2:0] op, input logic [63:0] night,
                                           input logic [31:0] now, input logic [5:0] flags);
    prefetch_req_t rq;
    rq.op = op;
    rq.night = night;
    rq.now = now;
    {rq.rt, rq.busy, rq.cat, rq.fa, rq.cov, rq.ok} = flags;
    return rq;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("ERROR at %0t: %s is %h, expected %h", $time, what, got, want);
  endtask

  // Sender: holds the request until the transfer, then either continues the
  // burst or goes quiet for a random gap.
  task automatic send_item(input prefetch_req_t rq);
    prefetch_stat_t st;
    op_d <= rq.op;
    night_d <= rq.night;
    now_d <= rq.now;
    rt_d <= rq.rt;
    busy_d <= rq.busy;
    cat_d <= rq.cat;
    fa_d <= rq.fa;
    cov_d <= rq.cov;
    ok_d <= rq.ok;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    step_controller(rq, st);
    status_due.push_back(st);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cooldown(input logic [31:0] value);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    ctl_cooldown = value;
  endtask

  function automatic logic [63:0] pick_night();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 64'd1700000000 + 64'd86400 * $urandom_range(0, 11);
    if (r < 78) return 64'd0;
    if (r < 90) return {$urandom, $urandom};
    if (r < 95) return '1;
    return 64'h8000_0000_0000_0000 | 64'($urandom_range(0, 3));
  endfunction

  // Random requests lean on the current phase so that most of them push the
  // controller through request, select, fetch and finish sequences.
  task automatic draw_req(output prefetch_req_t rq);
    int r;
    r = $urandom_range(0, 99);
    if (in_flight()) begin
      if (r < 60) rq.op = ppc_pkg::OP_SERVICE;
      else if (r < 70) rq.op = ppc_pkg::OP_QUERY;
      else if (r < 77) rq.op = ppc_pkg::OP_PREEMPT;
      else if (r < 84) rq.op = ppc_pkg::OP_YIELD;
      else if (r < 88) rq.op = ppc_pkg::OP_NIGHT;
      else if (r < 92) rq.op = ppc_pkg::OP_CANDIDATE;
      else if (r < 95) rq.op = ppc_pkg::OP_DRAINED;
      else rq.op = ppc_pkg::OP_FAILURE;
    end else begin
      if (r < 45) rq.op = ppc_pkg::OP_NIGHT;
      else if (r < 65) rq.op = ppc_pkg::OP_CANDIDATE;
      else if (r < 72) rq.op = ppc_pkg::OP_DRAINED;
      else if (r < 80) rq.op = ppc_pkg::OP_QUERY;
      else if (r < 85) rq.op = ppc_pkg::OP_FAILURE;
      else if (r < 90) rq.op = ppc_pkg::OP_SERVICE;
      else if (r < 94) rq.op = ppc_pkg::OP_PREEMPT;
      else rq.op = ppc_pkg::OP_YIELD;
    end
    rq.night = pick_night();
    r = $urandom_range(0, 39);
    if (r == 0) sim_now = $urandom;
    else if (r == 1) sim_now = 32'hFFFF_FFFF - $urandom_range(0, 5000);
    else sim_now = sim_now + $urandom_range(0, 3000);
    rq.now = sim_now;
    rq.rt = ($urandom_range(0, 9) == 0);
    rq.busy = ($urandom_range(0, 9) < 2);
    rq.cat = ($urandom_range(0, 9) < 2);
    rq.fa = (ctl_phase == ppc_pkg::PH_FETCHING) ? ($urandom_range(0, 9) < 7)
                                                : ($urandom_range(0, 3) == 0);
    rq.cov = ($urandom_range(0, 1) == 1);
    rq.ok = ($urandom_range(0, 9) < 8);
  endtask

  task automatic test_phase_flow();
    send_item(mk_req(ppc_pkg::OP_NIGHT, 64'd0, 32'd0, F_NONE));
    send_item(mk_req(ppc_pkg::OP_QUERY, '1, 32'hFFFF_FFFF, F_ALL));
    send_item(mk_req(ppc_pkg::OP_NIGHT, '1, 32'd10, F_NONE));
    // Requests and drain are refused while a night is in flight.
    send_item(mk_req(ppc_pkg::OP_CANDIDATE, 64'd0, 32'd20, F_NONE));
    send_item(mk_req(ppc_pkg::OP_DRAINED, 64'd0, 32'd30, F_NONE));
    send_item(mk_req(ppc_pkg::OP_SERVICE, 64'd0, 32'd40, F_BUSY | F_OK));
    // The fetch start is issued but refused: a failure with no cooldown entry.
    send_item(mk_req(ppc_pkg::OP_SERVICE, 64'd0, 32'd50, F_NONE));
    send_item(mk_req(ppc_pkg::OP_NIGHT, 64'd42, 32'd60, F_NONE));
    send_item(mk_req(ppc_pkg::OP_SERVICE, 64'd0, 32'd70, F_OK));
    send_item(mk_req(ppc_pkg::OP_SERVICE, 64'd0, 32'd80, F_RT | F_FA));
    send_item(mk_req(ppc_pkg::OP_YIELD, 64'd0, 32'd90, F_FA));
    send_item(mk_req(ppc_pkg::OP_NIGHT, 64'd43, 32'd100, F_NONE));
    send_item(mk_req(ppc_pkg::OP_SERVICE, 64'd0, 32'd110, F_OK));
    send_item(mk_req(ppc_pkg::OP_YIELD, 64'd0, 32'd120, F_FA));
    send_item(mk_req(ppc_pkg::OP_NIGHT, 64'd44, 32'd130, F_NONE));
    send_item(mk_req(ppc_pkg::OP_SERVICE, 64'd0, 32'd140, F_OK));
    send_item(mk_req(ppc_pkg::OP_SERVICE, 64'd0, 32'd150, F_COV));
    send_item(mk_req(ppc_pkg::OP_CANDIDATE, 64'd0, 32'd160, F_NONE));
    send_item(mk_req(ppc_pkg::OP_SERVICE, 64'd0, 32'd170, F_NONE));
    send_item(mk_req(ppc_pkg::OP_CANDIDATE, 64'd0, 32'd180, F_NONE));
    // A pending catalog refresh keeps the controller selecting.
    send_item(mk_req(ppc_pkg::OP_SERVICE, 64'd45, 32'd185, F_CAT));
    send_item(mk_req(ppc_pkg::OP_SERVICE, 64'd45, 32'd190, F_NONE));
    send_item(mk_req(ppc_pkg::OP_SERVICE, 64'd0, 32'd200, F_OK));
    send_item(mk_req(ppc_pkg::OP_PREEMPT, 64'd0, 32'd210, F_NONE));
    send_item(mk_req(ppc_pkg::OP_SERVICE, 64'd0, 32'd220, F_FA));
    // A preempt outside the busy phases is consumed without effect.
    send_item(mk_req(ppc_pkg::OP_PREEMPT, 64'd0, 32'd230, F_NONE));
    send_item(mk_req(ppc_pkg::OP_SERVICE, 64'd0, 32'd240, F_NONE));
  endtask

  task automatic test_cooldown_table();
    write_cooldown(32'hFFFF_FFFF);
    // The deadline wraps to zero here and must be stored as one.
    send_item(mk_req(ppc_pkg::OP_FAILURE, 64'd5, 32'd1, F_NONE));
    send_item(mk_req(ppc_pkg::OP_QUERY, 64'd5, 32'd0, F_NONE));
    send_item(mk_req(ppc_pkg::OP_QUERY, 64'd5, 32'd2, F_NONE));
    send_item(mk_req(ppc_pkg::OP_NIGHT, 64'd9, 32'd500, F_NONE));
    send_item(mk_req(ppc_pkg::OP_SERVICE, 64'd0, 32'd600, F_OK));
    send_item(mk_req(ppc_pkg::OP_SERVICE, 64'd0, 32'd1000, F_NONE));
    // Fill the table, then force a replacement of the earliest deadline.
    for (int i = 0; i < 7; i++)
      send_item(mk_req(ppc_pkg::OP_FAILURE, 64'd200 + 64'(i), 32'd5000 - 32'(i * 700),
                       F_NONE));
    send_item(mk_req(ppc_pkg::OP_FAILURE, 64'd5, 32'd7000, F_NONE));
    send_item(mk_req(ppc_pkg::OP_QUERY, 64'd206, 32'd1000, F_NONE));
  endtask

  task automatic test_random_traffic(input logic [31:0] cooldown, input int count);
    prefetch_req_t rq;
    write_cooldown(cooldown);
    repeat (count) begin
      draw_req(rq);
      send_item(rq);
    end
  endtask

  // Receiver: switches between always ready, random stalls and long stalls.
  int rx_mode = 0;
  int rx_left = 0;
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 2);
      rx_left <= $urandom_range(5, 40);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 9) < 6);
      default: out_ready <= (rx_left % 8 == 0);
    endcase
  end

  always @(posedge clk) begin : check_results
    prefetch_stat_t exp;
    if (!rst && out_valid && out_ready) begin
      if (status_due.size() == 0) begin
        report_mismatch("status transfer with nothing expected", '0, '0);
      end else begin
        exp = status_due.pop_front();
        if (accepted !== exp.acc)
          report_mismatch("accepted", 64'(accepted), 64'(exp.acc));
        if (phase_now !== exp.phase)
          report_mismatch("phase_now", 64'(phase_now), 64'(exp.phase));
        if (active_night_out !== exp.act)
          report_mismatch("active_night_out", active_night_out, exp.act);
        if (last_night_out !== exp.last)
          report_mismatch("last_night_out", last_night_out, exp.last);
        if (last_failed_out !== exp.lastf)
          report_mismatch("last_failed_out", last_failed_out, exp.lastf);
        if (completed_out !== exp.done_cnt)
          report_mismatch("completed_out", 64'(completed_out), 64'(exp.done_cnt));
        if (failed_out !== exp.fail_cnt)
          report_mismatch("failed_out", 64'(failed_out), 64'(exp.fail_cnt));
        if (cooldown_hit !== exp.cool)
          report_mismatch("cooldown_hit", 64'(cooldown_hit), 64'(exp.cool));
        if (fetch_request !== exp.freq)
          report_mismatch("fetch_request", 64'(fetch_request), 64'(exp.freq));
        if (abort_fetch !== exp.abort)
          report_mismatch("abort_fetch", 64'(abort_fetch), 64'(exp.abort));
        if (abort_reason !== exp.reason)
          report_mismatch("abort_reason", 64'(abort_reason), 64'(exp.reason));
      end
    end
  end

  // Watchdog: too many cycles without any transfer means the block hung.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("prefetch_phase_controller_with_cooldown: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_phase_flow();
    test_cooldown_table();
    test_random_traffic(ppc_pkg::COOLDOWN_RESET, 125);
    test_random_traffic(32'd0, 125);
    test_random_traffic($urandom_range(1, 20000), 125);
    test_random_traffic(32'hFFFF_FFFF, 125);
    wait_idle();
    if (mismatch_count == 0 && status_due.size() == 0) begin
      $display("prefetch_phase_controller_with_cooldown: match");
    end else begin
      $display("prefetch_phase_controller_with_cooldown: mismatch");
    end
    $finish;
  end

endmodule
